### hdl/cma_pkg.sv
// Shared types and operation codes for the 65C02-class ALU.
// No dependencies; imported by cma_adder, cma_alu and cmos_6502_alu_unit.
`timescale 1ns / 1ps

package cma_pkg;

  localparam logic [4:0] ACT_ROL    = 5'd0;
  localparam logic [4:0] ACT_ROR    = 5'd1;
  localparam logic [4:0] ACT_ASL    = 5'd2;
  localparam logic [4:0] ACT_LSR    = 5'd3;
  localparam logic [4:0] ACT_DEC    = 5'd4;
  localparam logic [4:0] ACT_INC    = 5'd5;
  localparam logic [4:0] ACT_TSB    = 5'd6;
  localparam logic [4:0] ACT_TRB    = 5'd7;
  localparam logic [4:0] ACT_SMB    = 5'd8;
  localparam logic [4:0] ACT_RMB    = 5'd9;
  localparam logic [4:0] ACT_LDA    = 5'd10;
  localparam logic [4:0] ACT_LDX    = 5'd11;
  localparam logic [4:0] ACT_LDY    = 5'd12;
  localparam logic [4:0] ACT_ORA    = 5'd13;
  localparam logic [4:0] ACT_AND    = 5'd14;
  localparam logic [4:0] ACT_EOR    = 5'd15;
  localparam logic [4:0] ACT_CMP    = 5'd16;
  localparam logic [4:0] ACT_CPX    = 5'd17;
  localparam logic [4:0] ACT_CPY    = 5'd18;
  localparam logic [4:0] ACT_BIT    = 5'd19;
  localparam logic [4:0] ACT_BIT_IM = 5'd20;
  localparam logic [4:0] ACT_ADC    = 5'd21;
  localparam logic [4:0] ACT_SBC    = 5'd22;

  typedef struct packed {
    logic [4:0] action;
    logic [7:0] operand;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic       c;
    logic       z;
    logic       n;
    logic       v;
    logic       dec;
    logic [2:0] bit_index;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] mem;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic       c;
    logic       z;
    logic       n;
    logic       v;
    logic       so;
  } alu_res_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       c;
    logic       v;
  } add_res_t;

endpackage

### hdl/cma_adder.sv
// Binary and BCD adder shared by ADC and SBC (SBC supplies the inverted operand).
// Depends on cma_pkg for the result struct.
`timescale 1ns / 1ps

module cma_adder (
  input  logic [7:0]        a,
  input  logic [7:0]        d,
  input  logic              cin,
  input  logic              dec,
  input  logic              sub,
  output cma_pkg::add_res_t res
);
  import cma_pkg::*;

  logic [8:0] bin_sum;
  logic [4:0] lo_raw;
  logic [5:0] lo_adj;
  logic       lo_carry;
  logic [8:0] hi_sum;
  logic [9:0] hi_adj;
  logic       dec_c;

  always_comb begin
    bin_sum = {1'b0, a} + {1'b0, d} + {8'd0, cin};
    lo_raw  = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, cin};
    if (!sub) begin
      lo_adj   = (lo_raw > 5'd9) ? ({1'b0, lo_raw} + 6'd6) : {1'b0, lo_raw};
      lo_carry = (lo_adj[5:4] != 2'b00);
    end else begin
      lo_adj   = (lo_raw <= 5'd15) ? ({1'b0, lo_raw} - 6'd6) : {1'b0, lo_raw};
      lo_carry = lo_raw[4];
    end
    hi_sum = {1'b0, a[7:4], 4'd0} + {1'b0, d[7:4], 4'd0} + {4'd0, lo_carry, 4'd0}
           + {5'd0, lo_adj[3:0]};
    // A subtracting adjust may go below zero; only the low byte is kept and C stays clear.
    if (!sub) begin
      hi_adj = (hi_sum > 9'h09f) ? ({1'b0, hi_sum} + 10'h060) : {1'b0, hi_sum};
      dec_c  = (hi_adj[9:8] != 2'b00);
    end else begin
      hi_adj = (hi_sum <= 9'h0ff) ? ({1'b0, hi_sum} - 10'h060) : {1'b0, hi_sum};
      dec_c  = hi_sum[8];
    end
    if (!dec) begin
      res.sum = bin_sum[7:0];
      res.c   = bin_sum[8];
      res.v   = ~(a[7] ^ d[7]) & (a[7] ^ bin_sum[7]);
    end else begin
      res.sum = hi_adj[7:0];
      res.c   = dec_c;
      res.v   = ~(a[7] ^ d[7]) & (a[7] ^ hi_sum[7]);
    end
  end

endmodule

### hdl/cma_alu.sv
// Operation decode and datapath of the ALU: one request in, one result out.
// Depends on cma_pkg and instantiates cma_adder.
`timescale 1ns / 1ps

module cma_alu (
  input  cma_pkg::alu_req_t req,
  output cma_pkg::alu_res_t res
);
  import cma_pkg::*;

  logic [7:0] add_d;
  logic       add_sub;
  add_res_t   add_res;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] bit_mask;
  logic [7:0] logic_val;

  assign add_sub = (req.action == ACT_SBC);
  assign add_d   = add_sub ? ~req.operand : req.operand;

  cma_adder u_adder (
    .a   (req.acc),
    .d   (add_d),
    .cin (req.c),
    .dec (req.dec),
    .sub (add_sub),
    .res (add_res)
  );

  always_comb begin
    res       = '{mem: req.operand, acc: req.acc, x: req.x, y: req.y,
                  c: req.c, z: req.z, n: req.n, v: req.v, so: 1'b0};
    cmp_reg   = (req.action == ACT_CMP) ? req.acc :
                (req.action == ACT_CPX) ? req.x : req.y;
    cmp_diff  = {1'b0, cmp_reg} - {1'b0, req.operand};
    bit_mask  = 8'd1 << req.bit_index;
    logic_val = req.acc;
    unique case (req.action) inside
      ACT_ROL: begin
        res.mem = {req.operand[6:0], req.c};
        res.c   = req.operand[7];
      end
      ACT_ROR: begin
        res.mem = {req.c, req.operand[7:1]};
        res.c   = req.operand[0];
      end
      ACT_ASL: begin
        res.mem = {req.operand[6:0], 1'b0};
        res.c   = req.operand[7];
      end
      ACT_LSR: begin
        res.mem = {1'b0, req.operand[7:1]};
        res.c   = req.operand[0];
      end
      ACT_DEC: res.mem = req.operand - 8'd1;
      ACT_INC: res.mem = req.operand + 8'd1;
      ACT_TSB: begin
        res.z   = ((req.operand & req.acc) == 8'd0);
        res.mem = req.operand | req.acc;
      end
      ACT_TRB: begin
        res.z   = ((req.operand & req.acc) == 8'd0);
        res.mem = req.operand & ~req.acc;
      end
      ACT_SMB: res.mem = req.operand | bit_mask;
      ACT_RMB: res.mem = req.operand & ~bit_mask;
      ACT_LDA: begin
        res.acc   = req.operand;
        logic_val = req.operand;
      end
      ACT_LDX: begin
        res.x     = req.operand;
        logic_val = req.operand;
      end
      ACT_LDY: begin
        res.y     = req.operand;
        logic_val = req.operand;
      end
      ACT_ORA: begin
        res.acc   = req.acc | req.operand;
        logic_val = res.acc;
      end
      ACT_AND: begin
        res.acc   = req.acc & req.operand;
        logic_val = res.acc;
      end
      ACT_EOR: begin
        res.acc   = req.acc ^ req.operand;
        logic_val = res.acc;
      end
      ACT_CMP, ACT_CPX, ACT_CPY: begin
        res.c     = ~cmp_diff[8];
        logic_val = cmp_diff[7:0];
      end
      ACT_BIT: begin
        res.z  = ((req.operand & req.acc) == 8'd0);
        res.v  = req.operand[6];
        res.n  = req.operand[7];
        res.so = 1'b1;
      end
      ACT_BIT_IM: res.z = ((req.operand & req.acc) == 8'd0);
      ACT_ADC, ACT_SBC: begin
        res.acc   = add_res.sum;
        res.c     = add_res.c;
        res.v     = add_res.v;
        res.so    = 1'b1;
        logic_val = add_res.sum;
      end
      default: ;
    endcase
    unique case (req.action) inside
      ACT_ROL, ACT_ROR, ACT_ASL, ACT_LSR, ACT_DEC, ACT_INC: begin
        res.n = res.mem[7];
        res.z = (res.mem == 8'd0);
      end
      ACT_LDA, ACT_LDX, ACT_LDY, ACT_ORA, ACT_AND, ACT_EOR, ACT_CMP, ACT_CPX,
      ACT_CPY, ACT_ADC, ACT_SBC: begin
        res.n = logic_val[7];
        res.z = (logic_val == 8'd0);
      end
      default: ;
    endcase
  end

endmodule

### hdl/cmos_6502_alu_unit.sv
// Top level of the 65C02-class ALU: request register, cma_alu datapath, result register.
// Depends on cma_pkg and instantiates cma_alu.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_ready    action, operand, A, X, Y, flags, bit index
//   out_*     output     out_valid / out_ready  memory byte, A, X, Y, flags, block_so
//
// A request is accepted into the request register; its result passes through the ALU
// into the result register once that register is free or emptied, and out_valid then rises.
// One request is accepted every cycle while results are taken.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result holds the result register, and the request register still
// accepts one further request before in_ready falls.
`timescale 1ns / 1ps

module cmos_6502_alu_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_action,
  input  logic [7:0] in_operand,
  input  logic [7:0] in_acc_in,
  input  logic [7:0] in_x_in,
  input  logic [7:0] in_y_in,
  input  logic       in_carry_in,
  input  logic       in_zero_in,
  input  logic       in_negative_in,
  input  logic       in_overflow_in,
  input  logic       in_decimal_mode,
  input  logic [2:0] in_bit_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_mem_out,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_x_out,
  output logic [7:0] out_y_out,
  output logic       out_carry_out,
  output logic       out_zero_out,
  output logic       out_negative_out,
  output logic       out_overflow_out,
  output logic       out_block_so
);
  import cma_pkg::*;

  logic     req_v_r;
  logic     req_v_nxt;
  alu_req_t req_r;
  logic     res_v_r;
  logic     res_v_nxt;
  alu_res_t res_r;
  alu_res_t res_nxt;
  logic     res_load;
  logic     req_load;

  assign res_load  = req_v_r && (!res_v_r || out_ready);
  assign in_ready  = !req_v_r || res_load;
  assign req_load  = in_valid && in_ready;
  assign req_v_nxt = req_load ? 1'b1 : (res_load ? 1'b0 : req_v_r);
  assign res_v_nxt = res_load ? 1'b1 : ((res_v_r && out_ready) ? 1'b0 : res_v_r);

  cma_alu u_alu (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r <= '{action: in_action, operand: in_operand, acc: in_acc_in, x: in_x_in,
                 y: in_y_in, c: in_carry_in, z: in_zero_in, n: in_negative_in,
                 v: in_overflow_in, dec: in_decimal_mode, bit_index: in_bit_index};
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_v_r;
  assign out_mem_out      = res_r.mem;
  assign out_acc_out      = res_r.acc;
  assign out_x_out        = res_r.x;
  assign out_y_out        = res_r.y;
  assign out_carry_out    = res_r.c;
  assign out_zero_out     = res_r.z;
  assign out_negative_out = res_r.n;
  assign out_overflow_out = res_r.v;
  assign out_block_so     = res_r.so;

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !req_v_r |-> in_ready)
    else $error("in_ready low with an empty request register");

  a_request_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> res_v_r)
    else $error("request left stage one but no result is valid");

  a_bit_blocks_so: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (req_r.action == ACT_BIT || req_r.action == ACT_ADC ||
     req_r.action == ACT_SBC)) |=> res_r.so)
    else $error("BIT, ADC or SBC result without block_so");

  a_nop_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && req_r.action > ACT_SBC) |=>
      (res_r.acc == $past(req_r.acc) && res_r.mem == $past(req_r.operand) && !res_r.so))
    else $error("unused code changed the accumulator or memory byte");
`endif

endmodule
